// ----- sv/multi_radix_display_counter_unit_macros.svh -----
// Assertion macros for the multi-radix display counter unit.
// Used by the top level only; relies on clk and rst_n in the including scope.
`ifndef MULTI_RADIX_DISPLAY_COUNTER_UNIT_MACROS_SVH
`define MULTI_RADIX_DISPLAY_COUNTER_UNIT_MACROS_SVH

`ifndef SYNTH
// Clocked check, switched off while reset is asserted.
`define MRDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds through reset.
`define MRDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MRDC_ASSERT(lbl, prop, msg)
`define MRDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/mrdc_pkg.sv -----
// Shared types, constants and helper functions for the multi-radix display counter.
// No dependencies; imported by mrdc_step and the top level.
`default_nettype none

package mrdc_pkg;

    localparam int COUNT_W = 14;
    localparam int BCD_W   = 16;
    localparam int DIGIT_W = 4;
    localparam int LED_W   = 8;
    localparam int BTN_W   = 4;
    localparam int WBIN_W  = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(10000);

    // Button bit positions, lowest set bit wins
    localparam int BTN_RADIX = 0;
    localparam int BTN_BIG   = 1;
    localparam int BTN_MID   = 2;
    localparam int BTN_ONE   = 3;

    // Register index of show_decimal_thousands (word index from paddr)
    localparam logic CFG_IDX_SHOW = 1'b0;

    typedef enum logic [1:0] {
        RADIX_DEC  = 2'd0,
        RADIX_OCT  = 2'd1,
        RADIX_QUAT = 2'd2,
        RADIX_BIN  = 2'd3
    } radix_t;

    typedef struct packed {
        radix_t               radix;
        logic [COUNT_W-1:0]   count;
        logic [BCD_W-1:0]     bcd;
    } state_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] d3;
        logic [DIGIT_W-1:0] d2;
        logic [DIGIT_W-1:0] d1;
        logic [DIGIT_W-1:0] d0;
        logic [LED_W-1:0]   led;
        logic               changed;
    } result_t;

    function automatic logic [LED_W-1:0] led_pattern(radix_t r);
        logic [LED_W-1:0] p;
        unique case (r)
            RADIX_DEC:  p = 8'd64;
            RADIX_OCT:  p = 8'd32;
            RADIX_QUAT: p = 8'd16;
            RADIX_BIN:  p = 8'd128;
        endcase
        return p;
    endfunction

    // Binary weight for the big (big=1) or mid (big=0) add button
    function automatic logic [WBIN_W-1:0] weight_bin(radix_t r, logic big);
        logic [WBIN_W-1:0] w;
        unique case (r)
            RADIX_DEC:  w = big ? 7'd100 : 7'd10;
            RADIX_OCT:  w = big ? 7'd64  : 7'd8;
            RADIX_QUAT: w = big ? 7'd16  : 7'd4;
            RADIX_BIN:  w = big ? 7'd4   : 7'd2;
        endcase
        return w;
    endfunction

    // Same weights as packed BCD
    function automatic logic [BCD_W-1:0] weight_bcd(radix_t r, logic big);
        logic [BCD_W-1:0] w;
        unique case (r)
            RADIX_DEC:  w = big ? 16'h0100 : 16'h0010;
            RADIX_OCT:  w = big ? 16'h0064 : 16'h0008;
            RADIX_QUAT: w = big ? 16'h0016 : 16'h0004;
            RADIX_BIN:  w = big ? 16'h0004 : 16'h0002;
        endcase
        return w;
    endfunction

    // Four-digit BCD add; carry out of the thousands digit drops (mod 10000)
    function automatic logic [BCD_W-1:0] bcd_add(logic [BCD_W-1:0] a, logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] s;
        logic             cy;
        logic [4:0]       t;
        s  = '0;
        cy = 1'b0;
        for (int i = 0; i < 4; i++) begin
            t = {1'b0, a[4*i +: 4]} + {1'b0, b[4*i +: 4]} + {4'b0, cy};
            if (t > 5'd9) begin
                t  = t + 5'd6;
                cy = 1'b1;
            end else begin
                cy = 1'b0;
            end
            s[4*i +: 4] = t[3:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mrdc_step.sv -----
// Next-state and display-digit logic for one button transaction.
// Depends on mrdc_pkg.
`default_nettype none

module mrdc_step (
    input  mrdc_pkg::state_t                cur,
    input  logic [mrdc_pkg::BTN_W-1:0]      buttons,
    input  logic                            show_thousands,
    output mrdc_pkg::state_t                nxt,
    output mrdc_pkg::result_t               res
);
    import mrdc_pkg::*;

    logic [WBIN_W-1:0]  add_bin;
    logic [BCD_W-1:0]   add_bcd;
    logic               changed;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] c;
    radix_t             radix_n;
    logic [BCD_W-1:0]   bcd_n;

    // Pick the action from the lowest set button
    always_comb
    begin
        radix_n = cur.radix;
        changed = 1'b0;
        add_bin = '0;
        add_bcd = '0;
        priority if (buttons[BTN_RADIX])
        begin
            radix_n = radix_t'(2'(cur.radix + 2'd1));
            changed = 1'b1;
        end
        else if (buttons[BTN_BIG])
        begin
            add_bin = weight_bin(cur.radix, 1'b1);
            add_bcd = weight_bcd(cur.radix, 1'b1);
        end
        else if (buttons[BTN_MID])
        begin
            add_bin = weight_bin(cur.radix, 1'b0);
            add_bcd = weight_bcd(cur.radix, 1'b0);
        end
        else if (buttons[BTN_ONE])
        begin
            add_bin = WBIN_W'(1);
            add_bcd = BCD_W'(1);
        end
        else
        begin
            // no button: hold count and radix
            add_bin = '0;
            add_bcd = '0;
        end
    end

    // Binary count wraps by one compare-subtract; the BCD copy wraps by itself
    always_comb
    begin
        sum = {1'b0, cur.count} + {{(COUNT_W+1-WBIN_W){1'b0}}, add_bin};
        if (sum >= {1'b0, COUNT_MOD})
            c = COUNT_W'(sum - {1'b0, COUNT_MOD});
        else
            c = sum[COUNT_W-1:0];
        bcd_n = bcd_add(cur.bcd, add_bcd);
    end

    assign nxt = {radix_n, c, bcd_n};

    // Display digits in the radix in force after this transaction
    always_comb
    begin
        res.led     = led_pattern(radix_n);
        res.changed = changed;
        unique case (radix_n)
            RADIX_DEC:
            begin
                res.d3 = show_thousands ? bcd_n[15:12] : '0;
                res.d2 = bcd_n[11:8];
                res.d1 = bcd_n[7:4];
                res.d0 = bcd_n[3:0];
            end
            RADIX_OCT:
            begin
                res.d3 = {1'b0, c[11:9]};
                res.d2 = {1'b0, c[8:6]};
                res.d1 = {1'b0, c[5:3]};
                res.d0 = {1'b0, c[2:0]};
            end
            RADIX_QUAT:
            begin
                res.d3 = {2'b0, c[7:6]};
                res.d2 = {2'b0, c[5:4]};
                res.d1 = {2'b0, c[3:2]};
                res.d0 = {2'b0, c[1:0]};
            end
            RADIX_BIN:
            begin
                res.d3 = {3'b0, c[3]};
                res.d2 = {3'b0, c[2]};
                res.d1 = {3'b0, c[1]};
                res.d0 = {3'b0, c[0]};
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/multi_radix_display_counter_unit.sv -----
// Multi-radix display counter: an accepted input transaction is held in the input
// register, then its result in the output register, which holds it under out_stall.
// Throughput is one transaction per cycle while the output is not stalled, set by the
// count/radix update loop. rst_n (asynchronous, active low) clears both pipeline valids,
// the count, its BCD copy, the radix (back to decimal) and the thousands-display flag.
`default_nettype none

module multi_radix_display_counter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB-style configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mrdc_pkg::PADDR_W-1:0]        paddr,
    input  logic [mrdc_pkg::PDATA_W-1:0]        pwdata,
    output logic [mrdc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mrdc_pkg::BTN_W-1:0]          buttons,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mrdc_pkg::DIGIT_W-1:0]        digit_thousands,
    output logic [mrdc_pkg::DIGIT_W-1:0]        digit_hundreds,
    output logic [mrdc_pkg::DIGIT_W-1:0]        digit_tens,
    output logic [mrdc_pkg::DIGIT_W-1:0]        digit_ones,
    output logic [mrdc_pkg::LED_W-1:0]          radix_led,
    output logic                                radix_changed
);
    import mrdc_pkg::*;

    // Configuration register
    logic show_reg;
    logic cfg_wr;

    // Input register stage
    logic               s0_valid_reg;
    logic [BTN_W-1:0]   s0_buttons_reg;

    // Architectural state: binary count, BCD copy of it and radix
    state_t             state_reg;
    state_t             state_next;

    // Result register stage
    logic               out_valid_reg;
    result_t            res_reg;
    result_t            res_next;

    logic               out_load;   // result register free to take a new transaction
    logic               s0_adv;     // input stage hands its transaction to the result stage
    logic               in_take;

    // Terms for the checks
    logic               bcd_ok;
    logic               radix_step;

    // ------------------------------------------------------------------
    // Configuration: writes land on the access phase; only word index 0 exists
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            show_reg <= 1'b0;
        else if (cfg_wr && (paddr[PADDR_W-1] == CFG_IDX_SHOW))
            show_reg <= pwdata[0];
    end

    assign prdata = (paddr[PADDR_W-1] == CFG_IDX_SHOW) ?
                    {{(PDATA_W-1){1'b0}}, show_reg} : '0;

    // ------------------------------------------------------------------
    // Handshake: the result register is free when empty or being drained;
    // the input register takes a new transaction when empty or moving on.
    // ------------------------------------------------------------------
    assign out_load = !out_valid_reg || !out_stall;
    assign s0_adv   = s0_valid_reg && out_load;
    assign in_stall = s0_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (in_take)
            s0_valid_reg <= 1'b1;
        else if (s0_adv)
            s0_valid_reg <= 1'b0;
    end

    // Payload: hold while stalled, capture on every accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
            s0_buttons_reg <= buttons;
    end

    // ------------------------------------------------------------------
    // Update logic: one pass from the input register to state and result
    // ------------------------------------------------------------------
    mrdc_step u_step (
        .cur            (state_reg),
        .buttons        (s0_buttons_reg),
        .show_thousands (show_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    // Advance the count and radix only when the transaction moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.radix <= RADIX_DEC;
            state_reg.count <= '0;
            state_reg.bcd   <= '0;
        end
        else if (s0_adv)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= s0_adv;
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv)
            res_reg <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign digit_thousands = res_reg.d3;
    assign digit_hundreds  = res_reg.d2;
    assign digit_tens      = res_reg.d1;
    assign digit_ones      = res_reg.d0;
    assign radix_led       = res_reg.led;
    assign radix_changed   = res_reg.changed;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    assign bcd_ok = (state_reg.bcd[15:12] <= 4'd9) && (state_reg.bcd[11:8] <= 4'd9) &&
                    (state_reg.bcd[7:4] <= 4'd9) && (state_reg.bcd[3:0] <= 4'd9);
    assign radix_step = s0_adv && res_next.changed;

`include "multi_radix_display_counter_unit_macros.svh"

    `MRDC_ASSERT(a_count_range, state_reg.count < COUNT_MOD, "count left its range")
    `MRDC_ASSERT(a_bcd_digits, bcd_ok, "BCD copy holds an invalid digit")
    `MRDC_ASSERT(a_led_onehot, out_valid_reg |-> $onehot(res_reg.led), "radix LED not one-hot")
    `MRDC_ASSERT(a_radix_count, radix_step |=> $stable(state_reg.count), "radix change moved count")

endmodule

`default_nettype wire
